FILE: rtl/core/grid_point_normal_estimator_unit_assert.svh
// Assertion macros shared by the grid point normal estimator RTL.
`ifndef GRID_POINT_NORMAL_ESTIMATOR_UNIT_ASSERT_SVH
`define GRID_POINT_NORMAL_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define GPNE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define GPNE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gpne_pkg.sv
// Types and constants shared by the grid point normal estimator.
package gpne_pkg;

  localparam int ONE_Q14 = 16384;
  localparam int DIM_W   = 13;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               point_ok;
  } req_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_ok;
  } rsp_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               ok;
  } mem_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dz;
  } nb_t;

  typedef struct packed {
    logic signed [50:0] x;
    logic signed [50:0] y;
    logic signed [50:0] z;
  } vec_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ok;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } unit_res_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_ROOT,
    U_CHK,
    U_DIV,
    U_DONE
  } unit_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_PAIR_CHK,
    S_MUL,
    S_UNIT_GO,
    S_UNIT_WAIT,
    S_NEXT,
    S_SUM_GO,
    S_SUM_WAIT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/core/grid_point_normal_estimator_unit.sv
// Top level of the grid point normal estimator: point store and query sequencer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | req_t: write point or query cell
//  rsp     | out       | rsp_valid / rsp_ready | rsp_t: Q1.14 normal and ok flag
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (frame size)
//
// A write request puts the point in the store at the edge that accepts it.
// A query reads the centre and four neighbours from the store, then per usable neighbour
// pair forms the cross product from six products and runs one pass of the shared
// normalising unit (shift, squares, square root, check, three divides, done), then one
// more pass on the sum; an invalid or out-of-frame centre goes straight to the result.
// Reset clears control state only; the store is undefined until written.
// Requests are taken only while idle; a result waiting on rsp does not block
// the next request, only the following result's delivery.
module grid_point_normal_estimator_unit
  import gpne_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

`include "grid_point_normal_estimator_unit_assert.svh"

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Point store.
  mem_word_t mem [CELLS];
  mem_word_t rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  state_t state, state_next;

  logic [8:0]         frame_cols;
  logic [8:0]         frame_rows;
  logic [DIM_W-1:0]   cols;
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   qcol;
  logic [DIM_W-1:0]   qrow;
  logic               in_frame;
  logic [2:0]         rd_cnt;
  mem_word_t          centre;
  nb_t                n0, n1, n2, n3;
  nb_t                nb_new;
  logic [2:0]         pair;
  logic [2:0]         mul_cnt;
  logic signed [24:0] op_a, op_b;
  logic signed [49:0] prod;
  vec_t               cp;
  logic signed [17:0] sum_x, sum_y, sum_z;
  logic               used;
  rsp_t               fin;
  logic               unit_start;
  vec_t               unit_vec;
  unit_res_t          unit_res;
  logic               req_acc;
  logic               rsp_load;
  logic [DIM_W-1:0]   cl, cr, rt, rb;

  assign req_ready = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign req_acc   = req_valid && req_ready;
  assign rsp_load  = (state == S_OUT) && (!rsp_valid || rsp_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= 9'd256;
      frame_rows <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_COLS: frame_cols <= cfg_data;
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective frame size: zero taken as one, larger sizes saturated to the store.
  always_comb begin
    if (frame_cols == '0) cols = DIM_W'(1);
    else if (int'(frame_cols) > MAX_COLS) cols = DIM_W'(MAX_COLS);
    else cols = DIM_W'(frame_cols);
    if (frame_rows == '0) rows = DIM_W'(1);
    else if (int'(frame_rows) > MAX_ROWS) rows = DIM_W'(MAX_ROWS);
    else rows = DIM_W'(frame_rows);
  end

  // Wrapped neighbour coordinates of the held query.
  assign cl = (qcol == '0) ? cols - DIM_W'(1) : qcol - DIM_W'(1);
  assign cr = (qcol == cols - DIM_W'(1)) ? '0 : qcol + DIM_W'(1);
  assign rt = (qrow == '0) ? rows - DIM_W'(1) : qrow - DIM_W'(1);
  assign rb = (qrow == rows - DIM_W'(1)) ? '0 : qrow + DIM_W'(1);

  // Read order: centre, left, top, right, bottom.
  always_comb begin
    case (rd_cnt)
      3'd0:    rd_addr = AW'(int'(qrow) * MAX_COLS + int'(qcol));
      3'd1:    rd_addr = AW'(int'(qrow) * MAX_COLS + int'(cl));
      3'd2:    rd_addr = AW'(int'(rt) * MAX_COLS + int'(qcol));
      3'd3:    rd_addr = AW'(int'(qrow) * MAX_COLS + int'(cr));
      default: rd_addr = AW'(int'(rb) * MAX_COLS + int'(qcol));
    endcase
  end

  assign wr_addr = AW'(int'(req.row) * MAX_COLS + int'(req.col));
  assign wr_en   = req_acc && (req.opcode == OP_WRITE) &&
                   (int'(req.col) < MAX_COLS) && (int'(req.row) < MAX_ROWS);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z, ok: req.point_ok};
    rd_data <= mem[rd_addr];
  end

  // Difference of the arriving neighbour to the centre.
  always_comb begin
    nb_new.ok = rd_data.ok;
    nb_new.dx = 25'(rd_data.x) - 25'(centre.x);
    nb_new.dy = 25'(rd_data.y) - 25'(centre.y);
    nb_new.dz = 25'(rd_data.z) - 25'(centre.z);
  end

  // Cross product operands: one product a cycle.
  always_comb begin
    case (mul_cnt)
      3'd0:    begin op_a = n0.dy; op_b = n1.dz; end
      3'd1:    begin op_a = n0.dz; op_b = n1.dy; end
      3'd2:    begin op_a = n0.dz; op_b = n1.dx; end
      3'd3:    begin op_a = n0.dx; op_b = n1.dz; end
      3'd4:    begin op_a = n0.dx; op_b = n1.dy; end
      default: begin op_a = n0.dy; op_b = n1.dx; end
    endcase
  end

  assign unit_start = (state == S_UNIT_GO) || (state == S_SUM_GO);
  always_comb begin
    if (state == S_SUM_GO) begin
      unit_vec.x = 51'(sum_x);
      unit_vec.y = 51'(sum_y);
      unit_vec.z = 51'(sum_z);
    end else begin
      unit_vec = cp;
    end
  end

  gpne_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .vec   (unit_vec),
    .res   (unit_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_acc && req.opcode == OP_COMPUTE) state_next = S_READ;
      end
      S_READ: begin
        if (rd_cnt == 3'd5) state_next = (in_frame && centre.ok) ? S_PAIR_CHK : S_OUT;
      end
      S_PAIR_CHK: begin
        if (pair == 3'd4) state_next = used ? S_SUM_GO : S_OUT;
        else if (n0.ok && n1.ok) state_next = S_MUL;
        else state_next = S_NEXT;
      end
      S_MUL:       if (mul_cnt == 3'd6) state_next = S_UNIT_GO;
      S_UNIT_GO:   state_next = S_UNIT_WAIT;
      S_UNIT_WAIT: if (unit_res.done) state_next = S_NEXT;
      S_NEXT:      state_next = S_PAIR_CHK;
      S_SUM_GO:    state_next = S_SUM_WAIT;
      S_SUM_WAIT:  if (unit_res.done) state_next = S_OUT;
      S_OUT:       if (rsp_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= fin;
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_acc && req.opcode == OP_COMPUTE) begin
          qcol     <= DIM_W'(req.col);
          qrow     <= DIM_W'(req.row);
          in_frame <= (DIM_W'(req.col) < cols) && (DIM_W'(req.row) < rows);
          rd_cnt   <= '0;
          pair     <= '0;
          used     <= 1'b0;
          sum_x    <= '0;
          sum_y    <= '0;
          sum_z    <= '0;
          fin      <= '0;
        end
      end
      S_READ: begin
        rd_cnt <= rd_cnt + 3'd1;
        if (rd_cnt == 3'd1) centre <= rd_data;
        if (rd_cnt >= 3'd2) begin
          // shift in: ends as left, top, right, bottom
          n0 <= n1;
          n1 <= n2;
          n2 <= n3;
          n3 <= nb_new;
        end
      end
      S_PAIR_CHK: begin
        mul_cnt <= '0;
        cp      <= '0;
      end
      S_MUL: begin
        mul_cnt <= mul_cnt + 3'd1;
        if (mul_cnt != 3'd6) prod <= op_a * op_b;
        case (mul_cnt)
          3'd1:    cp.x <= cp.x + 51'(prod);
          3'd2:    cp.x <= cp.x - 51'(prod);
          3'd3:    cp.y <= cp.y + 51'(prod);
          3'd4:    cp.y <= cp.y - 51'(prod);
          3'd5:    cp.z <= cp.z + 51'(prod);
          3'd6:    cp.z <= cp.z - 51'(prod);
          default: begin
          end
        endcase
      end
      S_UNIT_WAIT: begin
        if (unit_res.done && unit_res.ok) begin
          sum_x <= sum_x + 18'(unit_res.x);
          sum_y <= sum_y + 18'(unit_res.y);
          sum_z <= sum_z + 18'(unit_res.z);
          used  <= 1'b1;
        end
      end
      S_NEXT: begin
        // rotate so the next pair sits in n0, n1
        n0   <= n1;
        n1   <= n2;
        n2   <= n3;
        n3   <= n0;
        pair <= pair + 3'd1;
      end
      S_SUM_WAIT: begin
        if (unit_res.done && unit_res.ok) begin
          fin.normal_x  <= unit_res.x;
          fin.normal_y  <= unit_res.y;
          fin.normal_z  <= unit_res.z;
          fin.normal_ok <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  `GPNE_ASSERT_IMP(a_unit_free, unit_start, !unit_res.busy, "unit started while busy")
  `GPNE_ASSERT_NXT(a_query_reads, req_acc && req.opcode == OP_COMPUTE, state == S_READ,
                   "query did not start reading")
  `GPNE_ASSERT_IMP(a_nan_zero, rsp_valid && !rsp.normal_ok,
                   rsp.normal_x == 0 && rsp.normal_y == 0 && rsp.normal_z == 0,
                   "invalid normal carries non-zero fields")
  `GPNE_ASSERT_NXT(a_load_shows, rsp_load, rsp_valid, "loaded result not shown")

endmodule

FILE: rtl/core/gpne_unit.sv
// Iterative unit that scales a vector to a Q1.14 unit vector.
module gpne_unit
  import gpne_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  vec_t      vec,
  output unit_res_t res
);

  unit_state_t state, state_next;

  logic [50:0]        mag [3];
  logic               neg [3];
  logic [14:0]        quo [3];
  logic [39:0]        prod;
  logic [41:0]        sq;
  logic [41:0]        rn;
  logic [20:0]        root;
  logic [22:0]        rem;
  logic [20:0]        len;
  logic [20:0]        drem;
  logic [14:0]        dq;
  logic [1:0]         k;
  logic [4:0]         cnt;
  logic               ok;

  logic               shift_more;
  logic [22:0]        rem_t;
  logic [22:0]        trial;
  logic               root_ge;
  logic [34:0]        dnum;
  logic [21:0]        dt;
  logic               div_ge;
  logic [19:0]        mag_k;

  assign shift_more = (|mag[0][50:20]) | (|mag[1][50:20]) | (|mag[2][50:20]);
  assign rem_t      = {rem[20:0], rn[41:40]};
  assign trial      = {root, 2'b01};
  assign root_ge    = rem_t >= trial;
  assign mag_k      = (k == 2'd0) ? mag[0][19:0] : (k == 2'd1) ? mag[1][19:0] : mag[2][19:0];
  assign dnum       = {1'b0, mag_k, 14'b0} + {15'b0, len[20:1]};
  assign dt         = {drem, dq[14]};
  assign div_ge     = dt >= {1'b0, len};

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE:  if (start) state_next = U_SHIFT;
      U_SHIFT: if (!shift_more) state_next = U_SQ;
      U_SQ:    if (k == 2'd3) state_next = U_ROOT;
      U_ROOT:  if (cnt == 5'd20) state_next = U_CHK;
      U_CHK:   state_next = (root == '0) ? U_DONE : U_DIV;
      U_DIV:   if (cnt == 5'd15 && k == 2'd2) state_next = U_DONE;
      U_DONE:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    res.busy = state != U_IDLE;
    res.done = state == U_DONE;
    res.ok   = ok;
    res.x    = neg[0] ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
    res.y    = neg[1] ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
    res.z    = neg[2] ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          mag[0] <= vec.x[50] ? 51'(-vec.x) : 51'(vec.x);
          mag[1] <= vec.y[50] ? 51'(-vec.y) : 51'(vec.y);
          mag[2] <= vec.z[50] ? 51'(-vec.z) : 51'(vec.z);
          neg[0] <= vec.x[50];
          neg[1] <= vec.y[50];
          neg[2] <= vec.z[50];
          k      <= '0;
          sq     <= '0;
          ok     <= 1'b0;
        end
      end
      U_SHIFT: begin
        if (shift_more) begin
          mag[0] <= mag[0] >> 1;
          mag[1] <= mag[1] >> 1;
          mag[2] <= mag[2] >> 1;
        end
      end
      U_SQ: begin
        if (k != 2'd3) prod <= mag_k * mag_k;
        if (k != 2'd0) sq <= sq + {2'b0, prod};
        k <= k + 2'd1;
        if (k == 2'd3) begin
          rn   <= sq + {2'b0, prod};
          root <= '0;
          rem  <= '0;
          cnt  <= '0;
        end
      end
      U_ROOT: begin
        rn  <= rn << 2;
        cnt <= cnt + 5'd1;
        if (root_ge) begin
          rem  <= rem_t - trial;
          root <= {root[19:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[19:0], 1'b0};
        end
      end
      U_CHK: begin
        len <= root;
        ok  <= root != '0;
        k   <= '0;
        cnt <= '0;
      end
      U_DIV: begin
        if (cnt == 5'd0) begin
          drem <= {1'b0, dnum[34:15]};
          dq   <= dnum[14:0];
          cnt  <= 5'd1;
        end else begin
          drem <= div_ge ? 21'(dt - {1'b0, len}) : dt[20:0];
          dq   <= {dq[13:0], div_ge};
          if (cnt == 5'd15) begin
            quo[k] <= {dq[13:0], div_ge};
            k      <= k + 2'd1;
            cnt    <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
